### hw/rtl/dssq_pkg.sv
package dssq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DL_W = 32;
	localparam int ID_W = 16;
	localparam int CNT_OUT_W = 5;

	localparam logic [31:0] HALF_BIT = 32'h8000_0000;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_POLL = 2'd1;
	localparam logic [1:0] MODE_ALL = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic eval;
		logic ins;
		logic pop;
	} dssq_ctl_t;

	function automatic logic tick_before(input logic [DL_W-1:0] a, input logic [DL_W-1:0] b);
		logic [DL_W-1:0] diff;
		diff = a - b;
		return (a != b) && ((diff & HALF_BIT) != '0);
	endfunction

endpackage

### hw/rtl/dssq_cell.sv
module dssq_cell
	import dssq_pkg::*;
(
	input  logic            clk,
	input  dssq_ctl_t       ctl,
	input  logic            occupied,
	input  logic [DL_W-1:0] new_dl,
	input  logic [ID_W-1:0] new_id,
	input  logic            prev_hit,
	input  logic [DL_W-1:0] prev_dl,
	input  logic [ID_W-1:0] prev_id,
	input  logic [DL_W-1:0] next_dl,
	input  logic [ID_W-1:0] next_id,
	output logic [DL_W-1:0] dl,
	output logic [ID_W-1:0] id,
	output logic            hit
);

	logic [DL_W-1:0] dl_q;
	logic [ID_W-1:0] id_q;
	logic            match_q;

	assign dl = dl_q;
	assign id = id_q;
	assign hit = prev_hit | match_q;

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			match_q <= occupied ? tick_before(new_dl, dl_q) : 1'b1;
		end
		if (ctl.ins) begin
			if (prev_hit) begin
				dl_q <= prev_dl;
				id_q <= prev_id;
			end else if (match_q) begin
				dl_q <= new_dl;
				id_q <= new_id;
			end
		end else if (ctl.pop) begin
			dl_q <= next_dl;
			id_q <= next_id;
		end
	end

endmodule

### hw/rtl/deadline_sorted_sleep_queue.sv
// Deadline-sorted sleep queue: a chain of DEPTH cells kept in wake order.
// Input channel (in_valid/in_stall) carries mode, task_id, deadline, now;
// an item is taken when in_valid is high and in_stall is low.
// Output channel (out_valid/out_stall) carries woken_id, has_task, status,
// count and last; a result is taken when out_valid is high and out_stall low.
// Insert, poll and unused mode: one result. The item is latched in S_IDLE,
// every cell compares its deadline against the new one in S_EVAL, and in
// S_EXEC the result is loaded into the output register while the chain
// shifts on an insert or a poll that removes an entry. A new item is taken
// only once the last one is done, as in_stall is high outside S_IDLE.
// Remove-all with n entries: n results, head first, as the chain shifts
// toward the head, one per cycle while not stalled; one result when empty.
// While out_stall holds a result, one more item is taken and then waits in
// its last step with in_stall high until the held result leaves.
// Reset empties the queue and clears the output register; cell contents are
// not cleared.
module deadline_sorted_sleep_queue
	import dssq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [ID_W-1:0]      task_id,
	input  logic [DL_W-1:0]      deadline,
	input  logic [DL_W-1:0]      now,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ID_W-1:0]      woken_id,
	output logic                 has_task,
	output logic [1:0]           status,
	output logic [CNT_OUT_W-1:0] count,
	output logic                 last
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_EVAL, S_EXEC, S_DRAIN} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [1:0]      mode_q;
	logic [ID_W-1:0] id_q;
	logic [DL_W-1:0] dl_q;
	logic [DL_W-1:0] now_q;
	logic            not_due_q;
	logic            out_free;
	logic            full;
	dssq_ctl_t       ctl;

	logic [DL_W-1:0] dl_w [DEPTH];
	logic [ID_W-1:0] id_w [DEPTH];
	logic            hit_w [DEPTH];
	logic [DEPTH-1:0] occ;

	function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [CW-1:0] c);
		logic [CW+CNT_OUT_W-1:0] ext;
		ext = {{CNT_OUT_W{1'b0}}, c};
		return ext[CNT_OUT_W-1:0];
	endfunction

	assign out_free = !out_valid || !out_stall;
	assign full = (count_q == CW'(DEPTH));
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i] = (CW'(i) < count_q);
		end
	end

	always_comb begin
		ctl.eval = (state_q == S_EVAL);
		ctl.ins = (state_q == S_EXEC) && out_free && (mode_q == MODE_INSERT) && !full;
		ctl.pop = ((state_q == S_EXEC) && out_free && (mode_q == MODE_POLL) &&
			(count_q != '0) && !not_due_q) ||
			((state_q == S_DRAIN) && out_free);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic            p_hit;
		logic [DL_W-1:0] p_dl;
		logic [ID_W-1:0] p_id;
		logic [DL_W-1:0] n_dl;
		logic [ID_W-1:0] n_id;

		if (i == 0) begin : g_head
			assign p_hit = 1'b0;
			assign p_dl = dl_w[0];
			assign p_id = id_w[0];
		end else begin : g_mid
			assign p_hit = hit_w[i-1];
			assign p_dl = dl_w[i-1];
			assign p_id = id_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_dl = dl_w[i];
			assign n_id = id_w[i];
		end else begin : g_body
			assign n_dl = dl_w[i+1];
			assign n_id = id_w[i+1];
		end

		dssq_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occupied (occ[i]),
			.new_dl   (dl_q),
			.new_id   (id_q),
			.prev_hit (p_hit),
			.prev_dl  (p_dl),
			.prev_id  (p_id),
			.next_dl  (n_dl),
			.next_id  (n_id),
			.dl       (dl_w[i]),
			.id       (id_w[i]),
			.hit      (hit_w[i])
		);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			mode_q <= mode;
			id_q <= task_id;
			dl_q <= deadline;
			now_q <= now;
		end
		if (state_q == S_EVAL) begin
			not_due_q <= tick_before(now_q, dl_w[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid <= 1'b0;
			woken_id <= '0;
			has_task <= 1'b0;
			status <= ST_NONE;
			count <= '0;
			last <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						out_valid <= 1'b1;
						woken_id <= '0;
						has_task <= 1'b0;
						last <= 1'b1;
						status <= ST_NONE;
						count <= cnt_out(count_q);
						state_q <= S_IDLE;
						case (mode_q)
							MODE_INSERT: begin
								if (full) begin
									status <= ST_FULL;
								end else begin
									status <= ST_OK;
									count_q <= count_q + CW'(1);
									count <= cnt_out(count_q + CW'(1));
								end
							end
							MODE_POLL: begin
								if (count_q != '0 && !not_due_q) begin
									status <= ST_OK;
									woken_id <= id_w[0];
									has_task <= 1'b1;
									count_q <= count_q - CW'(1);
									count <= cnt_out(count_q - CW'(1));
								end
							end
							MODE_ALL: begin
								if (count_q != '0) begin
									out_valid <= 1'b0;
									state_q <= S_DRAIN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DRAIN: begin
					if (out_free) begin
						out_valid <= 1'b1;
						woken_id <= id_w[0];
						has_task <= 1'b1;
						status <= ST_OK;
						count <= '0;
						last <= (count_q == CW'(1));
						count_q <= count_q - CW'(1);
						if (count_q == CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
